### rtl/ob2_pkg.sv
// ob2_pkg: shared types for the operand2 barrel shifter
// shift kind codes and the decoded shift control record
// no dependencies
package ob2_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned AmtW  = 8;

	typedef enum logic [1:0] {
		SHIFT_LSL = 2'd0,
		SHIFT_LSR = 2'd1,
		SHIFT_ASR = 2'd2,
		SHIFT_ROR = 2'd3
	} shift_kind_t;

	typedef struct packed {
		logic [WordW-1:0] value;
		shift_kind_t      kind;
		logic [AmtW-1:0]  amount;
	} shift_ctl_t;

endpackage

### rtl/ob2_decode.sv
// ob2_decode: turns the 12-bit operand field into a shift request
// immediate mode becomes a rotate right of the 8-bit constant
// depends on ob2_pkg
module ob2_decode (
	input  logic [11:0]         operand_field,
	input  logic                immediate_mode,
	input  logic [31:0]         rm_value,
	input  logic [31:0]         rs_value,
	output ob2_pkg::shift_ctl_t ctl
);
	import ob2_pkg::*;

	always_comb begin
		if (immediate_mode) begin
			ctl.value  = {24'd0, operand_field[7:0]};
			ctl.kind   = SHIFT_ROR;
			ctl.amount = {3'd0, operand_field[11:8], 1'b0};
		end else begin
			ctl.value = rm_value;
			ctl.kind  = shift_kind_t'(operand_field[6:5]);
			if (operand_field[4]) begin
				ctl.amount = rs_value[7:0];
			end else begin
				ctl.amount = {3'd0, operand_field[11:7]};
			end
		end
	end

endmodule

### rtl/ob2_shift_core.sv
// ob2_shift_core: 32-bit barrel shifter for lsl, lsr, asr and ror
// amounts of 32 and up saturate, except ror which wraps
// depends on ob2_pkg
module ob2_shift_core (
	input  ob2_pkg::shift_ctl_t ctl,
	output logic [31:0]         result
);
	import ob2_pkg::*;

	logic        big;
	logic [4:0]  sh;
	logic [31:0] fill;
	logic [63:0] dbl;

	assign big  = |ctl.amount[7:5];
	assign sh   = ctl.amount[4:0];
	assign fill = {WordW{ctl.value[31]}};
	assign dbl  = {ctl.value, ctl.value} >> sh;

	always_comb begin
		if (ctl.amount == '0) begin
			result = ctl.value;
		end else begin
			case (ctl.kind)
				SHIFT_LSL: result = big ? '0 : (ctl.value << sh);
				SHIFT_LSR: result = big ? '0 : (ctl.value >> sh);
				SHIFT_ASR: result = big ? fill : 32'($signed(ctl.value) >>> sh);
				SHIFT_ROR: result = dbl[31:0];
				default:   result = ctl.value;
			endcase
		end
	end

endmodule

### rtl/operand2_barrel_shifter.sv
// operand2_barrel_shifter: second-operand shifter, top level
// input register, decode and shift, result register
// depends on ob2_pkg, ob2_decode, ob2_shift_core
//
// channel   signals                                             direction
// command   start, busy, operand_field, immediate_mode,         in
//           rm_value, rs_value
// result    done, shifted_value                                 out
//
// a beat is taken every cycle; busy stays low
// an accepted beat is held in the input register, decoded and shifted, then held in the
// result register, whose output is shown with done
// reset clears the valid flags only; payload registers are not reset
// the receiver cannot stall; done lasts exactly one cycle per beat
module operand2_barrel_shifter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] operand_field,
	input  logic        immediate_mode,
	input  logic [31:0] rm_value,
	input  logic [31:0] rs_value,
	output logic        done,
	output logic [31:0] shifted_value
);
	import ob2_pkg::*;

	logic        valid_s1;
	logic [11:0] operand_field_s1;
	logic        immediate_mode_s1;
	logic [31:0] rm_value_s1;
	logic [31:0] rs_value_s1;
	shift_ctl_t  ctl;
	logic [31:0] result;
	logic        valid_s2;
	logic [31:0] result_s2;
	logic        accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			operand_field_s1  <= operand_field;
			immediate_mode_s1 <= immediate_mode;
			rm_value_s1       <= rm_value;
			rs_value_s1       <= rs_value;
		end
		if (valid_s1) begin
			result_s2 <= result;
		end
	end

	ob2_decode u_decode (
		.operand_field  (operand_field_s1),
		.immediate_mode (immediate_mode_s1),
		.rm_value       (rm_value_s1),
		.rs_value       (rs_value_s1),
		.ctl            (ctl)
	);

	ob2_shift_core u_shift (
		.ctl    (ctl),
		.result (result)
	);

	assign done          = valid_s2;
	assign shifted_value = result_s2;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted beat did not produce a result after two cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a beat in flight");

	a_plain_imm: assert property (@(posedge clk) disable iff (!arst_n)
		accept && immediate_mode && (operand_field[11:8] == 4'd0) |=> ##1
		(shifted_value == {24'd0, $past(operand_field[7:0], 2)}))
		else $error("unrotated immediate not passed through");

endmodule
